// ----- hdl/vpa_pkg.sv -----
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package vpa_pkg;
    localparam int unsigned MaxHolesDefault = 16;
    localparam int unsigned MaxPartsDefault = 16;
    localparam int unsigned AddrW = 16;
    localparam int unsigned IdW = 8;
    localparam int unsigned StatusW = 3;
    localparam int unsigned CfgIdxW = 2;

    localparam logic [StatusW-1:0] ST_OK        = 3'd0;
    localparam logic [StatusW-1:0] ST_NO_SPACE  = 3'd1;
    localparam logic [StatusW-1:0] ST_FRAG      = 3'd2;
    localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

    localparam logic [CfgIdxW-1:0] REG_TOTAL    = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_RESERVED = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_FIT      = 2'd2;

    localparam logic [1:0] FIT_BEST  = 2'd0;
    localparam logic [1:0] FIT_WORST = 2'd1;
    localparam logic [1:0] FIT_FIRST = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/variable_partition_allocator_core.sv -----
// ----------------------------------------------------------------------------
// variable_partition_allocator_core
// Hole / partition table allocator with best, worst or first fit selection.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake        | Payload
// s_       | in  | tvalid/tready    | tdata: action[0] process_id[8:1] size[24:9]
// m_       | out | tvalid/tready    | tdata: status[2:0] base_address[18:3]
// cfg      | in  | cfg_we           | cfg_idx, cfg_wdata
//
// One request walks the partition table once and the hole table once or
// twice, one entry per cycle. s_tready is low meanwhile.
// Reset and layout writes rebuild both tables (valid bits and hole 0 only).
// A result held on m_ with m_tready low blocks the next request.
`default_nettype none
module variable_partition_allocator_core #(
    parameter int unsigned MAX_HOLES = vpa_pkg::MaxHolesDefault,
    parameter int unsigned MAX_PARTS = vpa_pkg::MaxPartsDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // action, process_id, request_size
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // status, base_address
    input  wire logic        cfg_we,
    input  wire logic [vpa_pkg::CfgIdxW-1:0] cfg_idx,
    input  wire logic [15:0] cfg_wdata
);
    import vpa_pkg::*;

    localparam int unsigned HW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int unsigned PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;
    localparam int unsigned HCW = $clog2(MAX_HOLES + 1);
    localparam int unsigned PCW = $clog2(MAX_PARTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PSCAN = 7'b0000010,
        S_HSCAN = 7'b0000100,
        S_SSCAN = 7'b0001000,
        S_FSCAN = 7'b0010000,
        S_APPLY = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] total_reg, reserved_reg;
    logic [1:0]  fit_reg;

    logic [AddrW-1:0] hole_base [MAX_HOLES];
    logic [AddrW-1:0] hole_size [MAX_HOLES];
    logic [MAX_HOLES-1:0] hole_valid_reg;
    logic [IdW-1:0]   part_owner [MAX_PARTS];
    logic [AddrW-1:0] part_base [MAX_PARTS];
    logic [AddrW-1:0] part_size [MAX_PARTS];
    logic [MAX_PARTS-1:0] part_valid_reg;

    logic             act_reg;
    logic [IdW-1:0]   id_reg;
    logic [AddrW-1:0] size_reg;
    logic [PCW-1:0]   pidx_reg;
    logic [HCW-1:0]   hidx_reg;
    logic             slot_ok_reg, pick_ok_reg, lo_ok_reg, up_ok_reg, fr_ok_reg;
    logic [PW-1:0]    slot_reg;
    logic [HW-1:0]    pick_reg, lo_reg, up_reg, fr_reg;
    logic [16:0]      sum_reg;
    logic [AddrW-1:0] fb_reg, fs_reg;   // freed base and size
    logic [StatusW-1:0] status_reg;
    logic [AddrW-1:0] out_base_reg;
    logic             layout_wr;

    logic [HW-1:0] hi;
    logic [PW-1:0] pi;
    logic          hv;
    logic [AddrW-1:0] cb, cs, pb, ps, hend;
    logic better;

    assign hi = hidx_reg[HW-1:0];
    assign pi = pidx_reg[PW-1:0];
    assign hv = hole_valid_reg[hi];
    assign cb = hole_base[hi];
    assign cs = hole_size[hi];
    assign pb = hole_base[pick_reg];
    assign ps = hole_size[pick_reg];
    assign hend = cb + cs;
    assign layout_wr = cfg_we && (cfg_idx == REG_TOTAL || cfg_idx == REG_RESERVED);

    // Shared comparator of the fit search.
    always_comb begin
        priority if (fit_reg == FIT_BEST) begin
            better = (cs < ps) || (cs == ps && cb < pb);
        end else if (fit_reg == FIT_WORST) begin
            better = (cs > ps) || (cs == ps && cb < pb);
        end else begin
            better = cb < pb;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {5'd0, out_base_reg, status_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_PSCAN;
            S_PSCAN: begin
                if (act_reg == ACT_ALLOC && size_reg == '0) state_next = S_OUT;
                else if (pidx_reg == PCW'(MAX_PARTS)) begin
                    if (act_reg == ACT_ALLOC) state_next = slot_ok_reg ? S_HSCAN : S_OUT;
                    else state_next = slot_ok_reg ? S_FSCAN : S_OUT;
                end else if (act_reg == ACT_FREE && part_valid_reg[pi]
                             && part_owner[pi] == id_reg) state_next = S_FSCAN;
                else if (act_reg == ACT_ALLOC && !part_valid_reg[pi]) state_next = S_HSCAN;
            end
            S_HSCAN: if (hidx_reg == HCW'(MAX_HOLES))
                         state_next = pick_ok_reg ? S_APPLY : S_SSCAN;
            S_SSCAN: if (hidx_reg == HCW'(MAX_HOLES)) state_next = S_OUT;
            S_FSCAN: if (hidx_reg == HCW'(MAX_HOLES))
                         state_next = (lo_ok_reg || up_ok_reg || fr_ok_reg) ? S_APPLY : S_OUT;
            S_APPLY: state_next = S_OUT;
            S_OUT:   if (m_tready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            total_reg <= 16'hFFFF;
            reserved_reg <= '0;
            fit_reg <= FIT_FIRST;
            hole_valid_reg <= MAX_HOLES'(1);
            part_valid_reg <= '0;
            hole_base[0] <= '0;
            hole_size[0] <= 16'hFFFF;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                if (cfg_idx == REG_TOTAL) total_reg <= cfg_wdata;
                if (cfg_idx == REG_RESERVED) reserved_reg <= cfg_wdata;
                if (cfg_idx == REG_FIT) fit_reg <= cfg_wdata[1:0];
            end
            if (layout_wr) begin
                logic [15:0] t, r;
                t = (cfg_idx == REG_TOTAL) ? cfg_wdata : total_reg;
                r = (cfg_idx == REG_RESERVED) ? cfg_wdata : reserved_reg;
                hole_base[0] <= r;
                hole_size[0] <= t - r;
                hole_valid_reg <= MAX_HOLES'(t > r);
                part_valid_reg <= '0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    act_reg <= s_tdata[0];
                    id_reg <= s_tdata[8:1];
                    size_reg <= s_tdata[24:9];
                    pidx_reg <= '0;
                    hidx_reg <= '0;
                    slot_ok_reg <= 1'b0;
                    pick_ok_reg <= 1'b0;
                    lo_ok_reg <= 1'b0;
                    up_ok_reg <= 1'b0;
                    fr_ok_reg <= 1'b0;
                    sum_reg <= '0;
                    out_base_reg <= '0;
                    status_reg <= ST_OK;
                end
                S_PSCAN: begin
                    if (act_reg == ACT_ALLOC && size_reg == '0) begin
                        status_reg <= ST_NO_SPACE;
                    end else if (pidx_reg == PCW'(MAX_PARTS)) begin
                        status_reg <= (act_reg == ACT_ALLOC) ? ST_FULL : ST_NOT_FOUND;
                    end else begin
                        pidx_reg <= pidx_reg + 1'b1;
                        if (act_reg == ACT_FREE && part_valid_reg[pi]
                            && part_owner[pi] == id_reg) begin
                            slot_ok_reg <= 1'b1;
                            slot_reg <= pi;
                            fb_reg <= part_base[pi];
                            fs_reg <= part_size[pi];
                        end else if (act_reg == ACT_ALLOC && !part_valid_reg[pi]) begin
                            slot_ok_reg <= 1'b1;
                            slot_reg <= pi;
                        end
                    end
                end
                S_HSCAN: begin
                    if (hidx_reg == HCW'(MAX_HOLES)) hidx_reg <= '0;
                    else begin
                        hidx_reg <= hidx_reg + 1'b1;
                        if (hv && cs >= size_reg && (!pick_ok_reg || better)) begin
                            pick_ok_reg <= 1'b1;
                            pick_reg <= hi;
                        end
                    end
                end
                S_SSCAN: begin
                    if (hidx_reg == HCW'(MAX_HOLES))
                        status_reg <= (sum_reg >= {1'b0, size_reg}) ? ST_FRAG : ST_NO_SPACE;
                    else begin
                        hidx_reg <= hidx_reg + 1'b1;
                        // Stop adding once bit 16 is set: the sum then exceeds any request.
                        if (hv && !sum_reg[16]) sum_reg <= sum_reg + {1'b0, cs};
                    end
                end
                S_FSCAN: begin
                    if (hidx_reg == HCW'(MAX_HOLES)) begin
                        if (!(lo_ok_reg || up_ok_reg || fr_ok_reg)) status_reg <= ST_FULL;
                    end else begin
                        hidx_reg <= hidx_reg + 1'b1;
                        if (!hv) begin
                            if (!fr_ok_reg) begin
                                fr_ok_reg <= 1'b1;
                                fr_reg <= hi;
                            end
                        end else if (!lo_ok_reg && hend == fb_reg
                                     && ({1'b0, cb} + {1'b0, cs}) < 17'h10000) begin
                            lo_ok_reg <= 1'b1;
                            lo_reg <= hi;
                        end else if (!up_ok_reg
                                     && {1'b0, cb} == {1'b0, fb_reg} + {1'b0, fs_reg}) begin
                            up_ok_reg <= 1'b1;
                            up_reg <= hi;
                        end
                    end
                end
                S_APPLY: begin
                    if (act_reg == ACT_ALLOC) begin
                        part_valid_reg[slot_reg] <= 1'b1;
                        part_owner[slot_reg] <= id_reg;
                        part_base[slot_reg] <= pb;
                        part_size[slot_reg] <= size_reg;
                        out_base_reg <= pb;
                        hole_base[pick_reg] <= pb + size_reg;
                        hole_size[pick_reg] <= ps - size_reg;
                        if (ps == size_reg) hole_valid_reg[pick_reg] <= 1'b0;
                    end else begin
                        part_valid_reg[slot_reg] <= 1'b0;
                        out_base_reg <= fb_reg;
                        if (lo_ok_reg && up_ok_reg) begin
                            hole_size[lo_reg] <= hole_size[lo_reg] + fs_reg + hole_size[up_reg];
                            hole_valid_reg[up_reg] <= 1'b0;
                        end else if (lo_ok_reg) begin
                            hole_size[lo_reg] <= hole_size[lo_reg] + fs_reg;
                        end else if (up_ok_reg) begin
                            hole_base[up_reg] <= fb_reg;
                            hole_size[up_reg] <= hole_size[up_reg] + fs_reg;
                        end else begin
                            hole_base[fr_reg] <= fb_reg;
                            hole_size[fr_reg] <= fs_reg;
                            hole_valid_reg[fr_reg] <= (fs_reg != '0);
                        end
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    ap_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready and result valid together");
    ap_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped");
    ap_err_base: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && status_reg != ST_OK |-> out_base_reg == '0)
        else $error("nonzero base on error");
endmodule
`default_nettype wire

// ----- verif/tb_variable_partition_allocator_core.sv -----
// ----------------------------------------------------------------------------
// Partition allocator testbench
// Drives allocate and free requests into the allocator across several layout
// and fit settings, predicts each status and base address, and checks every
// result transaction in order against the prediction.
// ----------------------------------------------------------------------------
`default_nettype none

class alloc_scoreboard;
    localparam int NH = 16;
    localparam int NP = 16;

    bit [15:0] total_units;
    bit [15:0] reserved_units;
    bit [1:0]  fit;
    bit [15:0] hb[NH];
    bit [15:0] hs[NH];
    bit        hv[NH];
    bit [7:0]  po[NP];
    bit [15:0] pb[NP];
    bit [15:0] ps[NP];
    bit        pv[NP];
    bit [2:0]  status_q[$];
    bit [15:0] base_q[$];
    int        errors;

    function new();
        total_units = 16'hFFFF;
        reserved_units = 0;
        fit = vpa_pkg::FIT_FIRST;
        errors = 0;
        rebuild();
    endfunction

    function void rebuild();
        for (int i = 0; i < NH; i++) begin
            hb[i] = 0; hs[i] = 0; hv[i] = 0;
        end
        for (int i = 0; i < NP; i++) begin
            po[i] = 0; pb[i] = 0; ps[i] = 0; pv[i] = 0;
        end
        hb[0] = reserved_units;
        if (total_units > reserved_units) begin
            hs[0] = total_units - reserved_units;
            hv[0] = 1;
        end
    endfunction

    function void write_reg(bit [1:0] idx, bit [15:0] val);
        if (idx == vpa_pkg::REG_TOTAL) begin
            total_units = val; rebuild();
        end else if (idx == vpa_pkg::REG_RESERVED) begin
            reserved_units = val; rebuild();
        end else if (idx == vpa_pkg::REG_FIT) begin
            fit = val[1:0];
        end
    endfunction

    function int live_parts();
        int n;
        n = 0;
        for (int i = 0; i < NP; i++) n += pv[i];
        return n;
    endfunction

    function int choose_hole(bit [15:0] sz);
        int pick;
        pick = -1;
        for (int i = 0; i < NH; i++) begin
            if (!hv[i] || hs[i] < sz) continue;
            if (pick < 0) pick = i;
            else if (fit == vpa_pkg::FIT_BEST) begin
                if (hs[i] < hs[pick] || (hs[i] == hs[pick] && hb[i] < hb[pick])) pick = i;
            end else if (fit == vpa_pkg::FIT_WORST) begin
                if (hs[i] > hs[pick] || (hs[i] == hs[pick] && hb[i] < hb[pick])) pick = i;
            end else if (hb[i] < hb[pick]) begin
                pick = i;
            end
        end
        return pick;
    endfunction

    function void note_request(bit act, bit [7:0] id, bit [15:0] sz);
        bit [2:0]  st;
        bit [15:0] base;
        int        slot, h, p, lo, up, fr;
        int unsigned sum, pend;
        st = vpa_pkg::ST_OK;
        base = 0;
        if (act == vpa_pkg::ACT_ALLOC) begin
            slot = -1;
            for (int i = 0; i < NP; i++)
                if (!pv[i] && slot < 0) slot = i;
            if (sz == 0) st = vpa_pkg::ST_NO_SPACE;
            else if (slot < 0) st = vpa_pkg::ST_FULL;
            else begin
                h = choose_hole(sz);
                if (h < 0) begin
                    sum = 0;
                    for (int i = 0; i < NH; i++) if (hv[i]) sum += hs[i];
                    st = (sum >= sz) ? vpa_pkg::ST_FRAG : vpa_pkg::ST_NO_SPACE;
                end else begin
                    pv[slot] = 1; po[slot] = id; pb[slot] = hb[h]; ps[slot] = sz;
                    base = hb[h];
                    hb[h] = hb[h] + sz;
                    hs[h] = hs[h] - sz;
                    if (hs[h] == 0) hv[h] = 0;
                end
            end
        end else begin
            p = -1;
            for (int i = 0; i < NP; i++)
                if (p < 0 && pv[i] && po[i] == id) p = i;
            if (p < 0) st = vpa_pkg::ST_NOT_FOUND;
            else begin
                lo = -1; up = -1; fr = -1;
                pend = pb[p] + ps[p];
                for (int i = 0; i < NH; i++) begin
                    if (!hv[i]) begin
                        if (fr < 0) fr = i;
                    end else if (lo < 0 && 32'(hb[i]) + hs[i] == pb[p]) lo = i;
                    else if (up < 0 && hb[i] == pend) up = i;
                end
                if (lo < 0 && up < 0 && fr < 0) st = vpa_pkg::ST_FULL;
                else begin
                    pv[p] = 0;
                    base = pb[p];
                    if (lo >= 0 && up >= 0) begin
                        hs[lo] = hs[lo] + ps[p] + hs[up];
                        hv[up] = 0;
                    end else if (lo >= 0) hs[lo] = hs[lo] + ps[p];
                    else if (up >= 0) begin
                        hb[up] = pb[p]; hs[up] = hs[up] + ps[p];
                    end else begin
                        hb[fr] = pb[p]; hs[fr] = ps[p]; hv[fr] = ps[p] != 0;
                    end
                end
            end
        end
        status_q.push_back(st);
        base_q.push_back(base);
    endfunction

    function void check_result(bit [2:0] st, bit [15:0] base);
        bit [2:0]  exp_st;
        bit [15:0] exp_base;
        if (status_q.size() == 0) begin
            $display("%0t: unexpected result status %0d base %0h", $time, st, base);
            errors++;
            return;
        end
        exp_st = status_q.pop_front();
        exp_base = base_q.pop_front();
        if (st !== exp_st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_st, st);
            errors++;
        end
        if (base !== exp_base) begin
            $display("%0t: base_address expected %0h actual %0h", $time, exp_base, base);
            errors++;
        end
    endfunction
endclass

module tb_variable_partition_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        cfg_we = 0;
    logic [vpa_pkg::CfgIdxW-1:0] cfg_idx = 0;
    logic [15:0] cfg_wdata = 0;

    alloc_scoreboard alloc_model = new();
    int  cycle_count = 0;
    bit  stall_mode = 0;
    bit [7:0] live_ids[$];

    variable_partition_allocator_core dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("variable_partition_allocator_core test failed");
            $finish;
        end
    end

    // Receiver: either always ready or stalling on a rotating pattern with random gaps.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            alloc_model.check_result(m_tdata[2:0], m_tdata[18:3]);
        if (!stall_mode) m_tready <= 1'b1;
        else m_tready <= (cycle_count % 7 < 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
    end

    task automatic write_reg(input bit [1:0] idx, input bit [15:0] val);
        cfg_we <= 1; cfg_idx <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 0;
        alloc_model.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (alloc_model.status_q.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send_request(input bit act, input bit [7:0] id, input bit [15:0] sz);
        s_tvalid <= 1;
        s_tdata <= {7'd0, sz, id, act};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        alloc_model.note_request(act, id, sz);
        if (act == vpa_pkg::ACT_ALLOC) live_ids.push_back(id);
        if ($urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
        end
    endtask

    task automatic random_phase(input int n, input int unsigned max_sz);
        bit [7:0] id;
        int k;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 55) begin
                id = (i % 9 == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
                send_request(vpa_pkg::ACT_ALLOC, id, 16'($urandom_range(1, max_sz)));
            end else if (live_ids.size() > 0 && $urandom_range(0, 9) != 0) begin
                k = $urandom_range(0, live_ids.size() - 1);
                id = live_ids[k];
                live_ids.delete(k);
                send_request(vpa_pkg::ACT_FREE, id, 16'($urandom));
            end else begin
                send_request(vpa_pkg::ACT_FREE, 8'($urandom), 16'($urandom));
            end
        end
        s_tvalid <= 0;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: extremes, zero size, table full, unknown id.
        send_request(vpa_pkg::ACT_ALLOC, 8'hFF, 16'hFFFF);
        send_request(vpa_pkg::ACT_ALLOC, 8'h00, 16'hFFFF);
        send_request(vpa_pkg::ACT_ALLOC, 8'h01, 16'd0);
        send_request(vpa_pkg::ACT_FREE, 8'hFF, 16'hFFFF);
        send_request(vpa_pkg::ACT_FREE, 8'hFF, 16'd0);
        send_request(vpa_pkg::ACT_ALLOC, 8'hAA, 16'h5555);
        for (int i = 0; i < 16; i++)
            send_request(vpa_pkg::ACT_ALLOC, 8'(i), 16'd100);
        send_request(vpa_pkg::ACT_FREE, 8'd3, 16'd0);
        send_request(vpa_pkg::ACT_FREE, 8'd5, 16'd0);
        send_request(vpa_pkg::ACT_ALLOC, 8'd7, 16'd150);
        s_tvalid <= 0;
        live_ids.delete();
        wait_drained();

        // Reserved not below total: nothing can be allocated.
        write_reg(vpa_pkg::REG_TOTAL, 16'd100);
        write_reg(vpa_pkg::REG_RESERVED, 16'd100);
        send_request(vpa_pkg::ACT_ALLOC, 8'd1, 16'd1);
        s_tvalid <= 0;
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            stall_mode = ph[0];
            live_ids.delete();
            write_reg(vpa_pkg::REG_FIT, 16'(ph % 4));
            write_reg(vpa_pkg::REG_TOTAL, ph == 7 ? 16'hFFFF : 16'($urandom_range(200, 2000)));
            write_reg(vpa_pkg::REG_RESERVED, 16'($urandom_range(0, 100)));
            random_phase(78, ph == 7 ? 16'hFFFF : 16'd300);
            wait_drained();
        end

        if (alloc_model.errors == 0)
            $display("variable_partition_allocator_core test passed");
        else
            $display("variable_partition_allocator_core test failed");
        $finish;
    end
endmodule

`default_nettype wire
